@@ rtl/crv_pkg.sv @@
// Shared constants for the restitution collision velocity block.
// No dependencies; every other file in rtl/ imports this package.
package crv_pkg;

  localparam int E_WIDTH = 17;
  localparam int E_FRAC  = 16;
  localparam logic [E_WIDTH-1:0] E_ONE = 17'h10000;

endpackage

@@ rtl/crv_lane.sv @@
// One axis of the collision response: products, restitution scaling and
// the numerator magnitudes for both bodies. Depends on crv_pkg.
module crv_lane #(
  parameter int W  = 32,
  parameter int MW = 2 * W + 5
) (
  input  logic                        clk,
  input  logic [2:0]                  adv,
  input  logic signed [W-1:0]         va,
  input  logic signed [W-1:0]         vb,
  input  logic [W-1:0]                ma,
  input  logic [W-1:0]                mb,
  input  logic [crv_pkg::E_WIDTH-1:0] e,
  output logic                        neg_a,
  output logic [MW-1:0]               mag_a,
  output logic                        neg_b,
  output logic [MW-1:0]               mag_b,
  output logic [W:0]                  msum
);
  import crv_pkg::*;

  localparam int PW  = 2 * W + 2;
  localparam int PEW = PW + E_WIDTH + 1;
  localparam int SW  = PEW + 1;

  logic signed [W:0]   diff;
  logic signed [W:0]   ma_s;
  logic signed [W:0]   mb_s;
  logic signed [W:0]   va_x;
  logic signed [W:0]   vb_x;
  logic signed [PW-1:0] pa_c;
  logic signed [PW-1:0] pb_c;
  logic signed [PW-1:0] ca_c;
  logic signed [PW-1:0] cb_c;

  // Stage 1 registers.
  logic signed [PW-1:0] pa1, pb1, ca1, cb1;
  logic [W:0]           s1;
  logic [E_WIDTH-1:0]   e1;
  logic signed [W-1:0]  va1, vb1;

  // Stage 2 registers.
  logic signed [PEW-1:0] pae2, pbe2, cs2;
  logic [W:0]            s2;
  logic signed [W-1:0]   va2, vb2;

  logic signed [E_WIDTH:0] e_s;
  logic signed [PW-1:0]    common;
  logic signed [SW-1:0]    na, nb;
  logic [SW-1:0]           abs_a, abs_b;
  logic                    byp;
  logic [W-1:0]            bva, bvb;

  assign ma_s = $signed({1'b0, ma});
  assign mb_s = $signed({1'b0, mb});
  assign va_x = {va[W-1], va};
  assign vb_x = {vb[W-1], vb};
  assign diff = vb_x - va_x;
  assign pa_c = PW'(diff * ma_s);
  assign pb_c = PW'(diff * mb_s);
  assign ca_c = PW'(va_x * ma_s);
  assign cb_c = PW'(vb_x * mb_s);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pa1 <= pa_c;
      pb1 <= pb_c;
      ca1 <= ca_c;
      cb1 <= cb_c;
      s1  <= {1'b0, ma} + {1'b0, mb};
      e1  <= e;
      va1 <= va;
      vb1 <= vb;
    end
  end

  assign e_s    = $signed({1'b0, e1});
  assign common = ca1 + cb1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      pae2 <= PEW'(pa1 * e_s);
      pbe2 <= PEW'(pb1 * e_s);
      cs2  <= {{(PEW - PW - E_FRAC){common[PW-1]}}, common, {E_FRAC{1'b0}}};
      s2   <= s1;
      va2  <= va1;
      vb2  <= vb1;
    end
  end

  // Body b sees the opposite velocity difference, hence the subtraction.
  assign na    = SW'(pbe2) + SW'(cs2);
  assign nb    = SW'(cs2) - SW'(pae2);
  assign abs_a = na[SW-1] ? SW'(-na) : SW'(na);
  assign abs_b = nb[SW-1] ? SW'(-nb) : SW'(nb);
  assign byp   = (s2 == '0);
  assign bva   = va2[W-1] ? W'(-va2) : W'(va2);
  assign bvb   = vb2[W-1] ? W'(-vb2) : W'(vb2);

  // With both masses zero the divider is fed the input velocity over one,
  // which passes it through unchanged.
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      if (byp) begin
        neg_a <= va2[W-1];
        mag_a <= MW'(bva);
        neg_b <= vb2[W-1];
        mag_b <= MW'(bvb);
        msum  <= (W+1)'(1);
      end else begin
        neg_a <= na[SW-1];
        mag_a <= abs_a[SW-1:E_FRAC];
        neg_b <= nb[SW-1];
        mag_b <= abs_b[SW-1:E_FRAC];
        msum  <= s2;
      end
    end
  end

endmodule

@@ rtl/crv_div.sv @@
// Pipelined restoring divider with truncation and signed saturation,
// one quotient bit per stage. Depends on crv_pkg.
module crv_div #(
  parameter int W  = 32,
  parameter int MW = 2 * W + 5
) (
  input  logic                clk,
  input  logic [W+1:0]        adv,
  input  logic                neg,
  input  logic [MW-1:0]       mag,
  input  logic [W:0]          den,
  output logic signed [W-1:0] result
);
  import crv_pkg::*;

  logic [W:0]   rem  [0:W];
  logic [W-1:0] low  [0:W];
  logic [W-1:0] quo  [0:W];
  logic [W:0]   dv   [0:W];
  logic         ov   [0:W];
  logic         sg   [0:W];
  logic [W-1:0] lim;
  logic [W-1:0] val;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ov[0]  <= (mag >= MW'({den, {W{1'b0}}}));
      rem[0] <= mag[2*W:W];
      low[0] <= mag[W-1:0];
      quo[0] <= '0;
      dv[0]  <= den;
      sg[0]  <= neg;
    end
  end

  for (genvar j = 1; j <= W; j++) begin : g_step
    logic [W+1:0] trial;
    logic         take;
    assign trial = {rem[j-1], low[j-1][W-1]};
    assign take  = (trial >= {1'b0, dv[j-1]});
    always_ff @(posedge clk) begin
      if (adv[j]) begin
        rem[j] <= take ? (W+1)'(trial - {1'b0, dv[j-1]}) : trial[W:0];
        low[j] <= {low[j-1][W-2:0], 1'b0};
        quo[j] <= {quo[j-1][W-2:0], take};
        dv[j]  <= dv[j-1];
        ov[j]  <= ov[j-1];
        sg[j]  <= sg[j-1];
      end
    end
  end

  assign lim = sg[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign val = (ov[W] || (quo[W] > lim)) ? lim : quo[W];

  always_ff @(posedge clk) begin
    if (adv[W+1]) begin
      result <= sg[W] ? $signed(W'(-val)) : $signed(val);
    end
  end

endmodule

@@ rtl/restitution_collision_velocity_top.sv @@
// Top level of the restitution collision velocity block: handshake,
// restitution register and three axis lanes with six dividers.
// Depends on crv_pkg, crv_lane and crv_div.
//
// Usage: present two bodies' velocities and masses on the input channel
// (in_valid/in_ready); each accepted beat yields exactly one beat of new
// velocities on the output channel (out_valid/out_ready), in order.
// The restitution coefficient is written through cfg_we/cfg_data and is
// taken as one when it is written above one; write it only while idle.
// The pipeline has three lane stages for products and numerators, one
// range check stage, one stage per quotient bit in the dividers and one
// output register. Throughput is one beat per cycle while out_ready is
// high. Each stage advances when its successor is empty or advancing, so a
// stalled receiver only holds the last stage and the pipeline keeps taking
// beats until it is full.
// Reset clears all valid bits and sets the coefficient to one.
module restitution_collision_velocity_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [crv_pkg::E_WIDTH-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] vel_a_x,
  input  logic signed [VALUE_WIDTH-1:0] vel_a_y,
  input  logic signed [VALUE_WIDTH-1:0] vel_a_z,
  input  logic signed [VALUE_WIDTH-1:0] vel_b_x,
  input  logic signed [VALUE_WIDTH-1:0] vel_b_y,
  input  logic signed [VALUE_WIDTH-1:0] vel_b_z,
  input  logic [VALUE_WIDTH-1:0]        mass_a,
  input  logic [VALUE_WIDTH-1:0]        mass_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] new_vel_a_x,
  output logic signed [VALUE_WIDTH-1:0] new_vel_a_y,
  output logic signed [VALUE_WIDTH-1:0] new_vel_a_z,
  output logic signed [VALUE_WIDTH-1:0] new_vel_b_x,
  output logic signed [VALUE_WIDTH-1:0] new_vel_b_y,
  output logic signed [VALUE_WIDTH-1:0] new_vel_b_z
);
  import crv_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int MW = 2 * W + 5;
  localparam int NS = W + 5;

  logic [E_WIDTH-1:0] restitution;
  logic [E_WIDTH-1:0] e_eff;
  logic [NS-1:0]      valid;
  logic [NS-1:0]      rdy;

  logic signed [W-1:0] va [0:2];
  logic signed [W-1:0] vb [0:2];
  logic signed [W-1:0] ra [0:2];
  logic signed [W-1:0] rb [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= E_ONE;
    end else if (cfg_we) begin
      restitution <= cfg_data;
    end
  end

  assign e_eff = (restitution > E_ONE) ? E_ONE : restitution;

  assign rdy[NS-1] = !valid[NS-1] || out_ready;
  for (genvar i = 0; i < NS - 1; i++) begin : g_rdy
    assign rdy[i] = !valid[i] || rdy[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (rdy[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid[NS-1];

  assign va[0] = vel_a_x;
  assign va[1] = vel_a_y;
  assign va[2] = vel_a_z;
  assign vb[0] = vel_b_x;
  assign vb[1] = vel_b_y;
  assign vb[2] = vel_b_z;

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    logic          neg_a, neg_b;
    logic [MW-1:0] mag_a, mag_b;
    logic [W:0]    msum;

    crv_lane #(.W(W), .MW(MW)) u_lane (
      .clk   (clk),
      .adv   (rdy[2:0]),
      .va    (va[ax]),
      .vb    (vb[ax]),
      .ma    (mass_a),
      .mb    (mass_b),
      .e     (e_eff),
      .neg_a (neg_a),
      .mag_a (mag_a),
      .neg_b (neg_b),
      .mag_b (mag_b),
      .msum  (msum)
    );

    crv_div #(.W(W), .MW(MW)) u_div_a (
      .clk    (clk),
      .adv    (rdy[NS-1:3]),
      .neg    (neg_a),
      .mag    (mag_a),
      .den    (msum),
      .result (ra[ax])
    );

    crv_div #(.W(W), .MW(MW)) u_div_b (
      .clk    (clk),
      .adv    (rdy[NS-1:3]),
      .neg    (neg_b),
      .mag    (mag_b),
      .den    (msum),
      .result (rb[ax])
    );
  end

  assign new_vel_a_x = ra[0];
  assign new_vel_a_y = ra[1];
  assign new_vel_a_z = ra[2];
  assign new_vel_b_x = rb[0];
  assign new_vel_b_y = rb[1];
  assign new_vel_b_z = rb[2];

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for restitution_collision_velocity_top.
// Depends on crv_pkg and the RTL under rtl/; expected velocities come from an
// internal wide-integer predictor and are checked beat by beat in order.
module tb;
  import crv_pkg::*;

  typedef struct {
    logic signed [31:0] v[6];
  } vel6_t;

  typedef struct {
    logic signed [31:0] v[6];
    logic [31:0]        ma;
    logic [31:0]        mb;
  } bodies_t;

  typedef struct {
    bodies_t b;
    bit      known;
    vel6_t   res;
  } row_t;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 45;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [E_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] vel_a_x = '0, vel_a_y = '0, vel_a_z = '0;
  logic signed [31:0] vel_b_x = '0, vel_b_y = '0, vel_b_z = '0;
  logic [31:0] mass_a = '0, mass_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] new_vel_a_x, new_vel_a_y, new_vel_a_z;
  logic signed [31:0] new_vel_b_x, new_vel_b_y, new_vel_b_z;

  logic [E_WIDTH-1:0] coeff_reg;
  vel6_t pending_vels[$];
  row_t directed[$];
  int mismatches = 0;
  bit calm = 1'b0;
  int hold_left = 0;

  restitution_collision_velocity_top u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .vel_a_x(vel_a_x), .vel_a_y(vel_a_y), .vel_a_z(vel_a_z),
    .vel_b_x(vel_b_x), .vel_b_y(vel_b_y), .vel_b_z(vel_b_z),
    .mass_a(mass_a), .mass_b(mass_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .new_vel_a_x(new_vel_a_x), .new_vel_a_y(new_vel_a_y), .new_vel_a_z(new_vel_a_z),
    .new_vel_b_x(new_vel_b_x), .new_vel_b_y(new_vel_b_y), .new_vel_b_z(new_vel_b_z)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic signed [31:0] clamp_vel(logic signed [127:0] q);
    if (q > 128'sd2147483647) return 32'sh7fffffff;
    if (q < -128'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  // Exact 128-bit evaluation of both momentum-exchange formulas per axis;
  // SystemVerilog signed division already truncates toward zero.
  function automatic vel6_t bounce(bodies_t b, logic [E_WIDTH-1:0] coeff);
    logic [E_WIDTH-1:0] ec;
    logic signed [127:0] va, vb, ma, mb, e, shared, den, na, nb;
    vel6_t r;
    ec = (coeff > E_ONE) ? E_ONE : coeff;
    e = {111'd0, ec};
    ma = {96'd0, b.ma};
    mb = {96'd0, b.mb};
    for (int ax = 0; ax < 3; ax++) begin
      if (b.ma == 0 && b.mb == 0) begin
        r.v[ax] = b.v[ax];
        r.v[ax+3] = b.v[ax+3];
      end else begin
        va = b.v[ax];
        vb = b.v[ax+3];
        shared = (ma * va + mb * vb) <<< E_FRAC;
        den = (ma + mb) <<< E_FRAC;
        na = mb * e * (vb - va) + shared;
        nb = ma * e * (va - vb) + shared;
        r.v[ax] = clamp_vel(na / den);
        r.v[ax+3] = clamp_vel(nb / den);
      end
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rand_vel();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $signed($urandom_range(1 << 20)) - (1 << 19);
      2: return ($urandom_range(1)) ? 32'sh7fffffff - $urandom_range(15)
                                    : 32'sh80000000 + $urandom_range(15);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(3))
      0: return $urandom() | 32'd1;
      1: return $urandom_range(1, 1 << 18);
      2: return ($urandom_range(1)) ? 32'd1 : 32'hffffffff;
      default: return $urandom_range(1, 1 << 22);
    endcase
  endfunction

  task automatic add_row(logic signed [31:0] ax, ay, az, bx, by, bz,
                         logic [31:0] ma, mb, bit known, vel6_t res);
    row_t r;
    r.b.v = '{ax, ay, az, bx, by, bz};
    r.b.ma = ma;
    r.b.mb = mb;
    r.known = known;
    r.res = res;
    directed.push_back(r);
  endtask

  // Presents one beat and returns after the edge that accepts it.
  task automatic offer(bodies_t b, bit known, vel6_t res, bit may_idle);
    if (may_idle && !calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    vel_a_x <= b.v[0]; vel_a_y <= b.v[1]; vel_a_z <= b.v[2];
    vel_b_x <= b.v[3]; vel_b_y <= b.v[4]; vel_b_z <= b.v[5];
    mass_a <= b.ma;
    mass_b <= b.mb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_vels.push_back(known ? res : bounce(b, coeff_reg));
  endtask

  task automatic drain_and_set(logic [E_WIDTH-1:0] value);
    in_valid <= 1'b0;
    while (pending_vels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    coeff_reg = value;
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls plus one long hold-off requested by the sender.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  always @(posedge clk) begin
    vel6_t want, got;
    bit bad;
    if (!rst && out_valid && out_ready) begin
      got.v = '{new_vel_a_x, new_vel_a_y, new_vel_a_z,
                new_vel_b_x, new_vel_b_y, new_vel_b_z};
      if (pending_vels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected output beat");
      end else begin
        want = pending_vels.pop_front();
        bad = 1'b0;
        for (int i = 0; i < 6; i++) begin
          if (got.v[i] !== want.v[i]) begin
            bad = 1'b1;
            if (mismatches < 10)
              $display("ERROR: field %0d expected %h got %h", i, want.v[i], got.v[i]);
          end
        end
        if (bad) mismatches++;
      end
    end
  end

  initial begin
    logic [E_WIDTH-1:0] phase_coeff[5];
    vel6_t none, zeros, same;
    bodies_t b;
    none.v = '{0, 0, 0, 0, 0, 0};
    zeros = none;
    coeff_reg = E_ONE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows; the coefficient is still at its reset value of one.
    add_row(0, 0, 0, 0, 0, 0, 32'h10000, 32'h10000, 1'b1, zeros);
    // Both masses zero pass the velocities through.
    same.v = '{32'sh7fffffff, -32'sd5, 32'sh80000000, 32'sd123, 32'sh12345678, -32'sd1};
    add_row(same.v[0], same.v[1], same.v[2], same.v[3], same.v[4], same.v[5],
            0, 0, 1'b1, same);
    // Equal masses in a fully elastic collision swap the velocities.
    same.v = '{32'sh80000000, 32'sh7fffffff, -32'sd1, 32'sh7fffffff, 32'sh80000000, 32'sd1};
    add_row(same.v[3], same.v[4], same.v[5], same.v[0], same.v[1], same.v[2],
            32'hffffffff, 32'hffffffff, 1'b1, same);
    same.v = '{32'sd65536, -32'sd65536, 32'sd3, 32'sd0, 32'sd7, -32'sd9};
    add_row(same.v[3], same.v[4], same.v[5], same.v[0], same.v[1], same.v[2],
            32'd1, 32'd1, 1'b1, same);
    // One mass zero, extreme mass ratios and extreme velocities.
    add_row(32'sh7fffffff, 32'sh80000000, 5, 32'sh80000000, 32'sh7fffffff, -5,
            0, 32'd1, 1'b0, none);
    add_row(32'sh7fffffff, 32'sh80000000, 5, 32'sh80000000, 32'sh7fffffff, -5,
            32'hffffffff, 0, 1'b0, none);
    add_row(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
            32'sh80000000, 32'd1, 32'hffffffff, 1'b0, none);
    add_row(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
            32'sh80000000, 32'hffffffff, 32'd1, 1'b0, none);
    add_row(-32'sd1, 32'sd1, 32'sh55555555, 32'sd1, -32'sd1, 32'shaaaaaaaa,
            32'h00030000, 32'h00010000, 1'b0, none);
    add_row(32'sh00020000, -32'sh00018000, 32'sd0, -32'sh00010000, 32'sd0, 32'sh00040000,
            32'h80000000, 32'h7fffffff, 1'b0, none);
    foreach (directed[i]) offer(directed[i].b, directed[i].known, directed[i].res, 1'b0);

    drain_and_set(17'h1ffff);
    add_row(32'sh7fffffff, 1, 2, 32'sh80000000, 3, 4, 32'd7, 32'd9, 1'b0, none);
    offer(directed[directed.size()-1].b, 1'b0, none, 1'b0);

    phase_coeff = '{17'd0, 17'h1ffff, 17'h08000, 17'd0, E_ONE};
    phase_coeff[3] = E_WIDTH'($urandom_range(E_ONE));
    for (int ph = 0; ph < 5; ph++) begin
      drain_and_set(phase_coeff[ph]);
      for (int n = 0; n < 150; n++) begin
        calm = (ph == 2);
        if (ph == 3 && n == 20) hold_left = HOLD_CYCLES;
        for (int i = 0; i < 6; i++) b.v[i] = rand_vel();
        b.ma = rand_mass();
        b.mb = rand_mass();
        offer(b, 1'b0, none, 1'b1);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    while (pending_vels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/crv_pkg.sv
rtl/crv_lane.sv
rtl/crv_div.sv
rtl/restitution_collision_velocity_top.sv
tb/sv/tb.sv
